// ===== src/fmbq_pkg.sv =====
// shared types and constants for the front/middle/back queue
package fmbq_pkg;

   localparam int DATA_W = 32;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT  = 3'd0,
      ACT_PUSH_MIDDLE = 3'd1,
      ACT_PUSH_BACK   = 3'd2,
      ACT_POP_FRONT   = 3'd3,
      ACT_POP_MIDDLE  = 3'd4,
      ACT_POP_BACK    = 3'd5
   } action_type;

   typedef logic signed [DATA_W-1:0] data_type;

endpackage

// ===== src/front_middle_back_queue_core.sv =====
// top level of the front/middle/back queue: shifting cell store and result register
//
// usage:
//   req channel carries one operation per word: the action code on req_tuser and
//   the value to insert on req_tdata. push front, middle or back inserts at
//   position 0, count/2 or count; pop front, middle or back removes position 0,
//   (count-1)/2 or count-1. entries behind the point shift by one cell.
//   rsp channel returns exactly one word per request: the popped value on
//   rsp_tdata (-1 for a pop on an empty queue, 0 for pushes) and the empty and
//   full flags on rsp_tuser. a push into a full queue is dropped; codes 6 and 7
//   change nothing and return all zeros.
//   the response is registered and shows the cycle after the request. throughput is one word per
//   cycle, set by the single pass of the cell shift network and the output
//   register; a new request is taken while the held response is taken.
//   when rsp_tready is low with a response held, req_tready drops until the
//   response leaves.
//   reset clears the fill count and the response valid; cell contents are left
//   as they are and only positions below the count are ever read.
module front_middle_back_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // popped_value[31:0]
   output logic [1:0]  rsp_tuser    // was_empty[0], was_full[1]
);
   import fmbq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [DATA_W-1:0] cell_ff [CAPACITY];
   logic [DATA_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff, rsp_full_in;

   action_type        act;
   logic              accept;
   logic              is_push, is_pop, is_full, is_empty;
   logic              push_ok, pop_ok;
   logic [CNT_W-1:0]  pos;
   logic [IDX_W-1:0]  pos_idx;

   assign act      = action_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   always_comb begin
      is_push = 1'b0;
      is_pop  = 1'b0;
      pos     = '0;
      unique case (act)
         ACT_PUSH_FRONT: begin
            is_push = 1'b1;
         end
         ACT_PUSH_MIDDLE: begin
            is_push = 1'b1;
            pos     = count_ff >> 1;
         end
         ACT_PUSH_BACK: begin
            is_push = 1'b1;
            pos     = count_ff;
         end
         ACT_POP_FRONT: begin
            is_pop = 1'b1;
         end
         ACT_POP_MIDDLE: begin
            is_pop = 1'b1;
            pos    = (count_ff - 1'b1) >> 1;
         end
         ACT_POP_BACK: begin
            is_pop = 1'b1;
            pos    = count_ff - 1'b1;
         end
         default: begin
            is_push = 1'b0;
         end
      endcase
   end

   assign push_ok = is_push && !is_full;
   assign pop_ok  = is_pop && !is_empty;
   assign pos_idx = pos[IDX_W-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = cell_ff[i];
      end else begin : g_prev
         assign prev_w = cell_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = cell_ff[i];
      end else begin : g_next
         assign next_w = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (push_ok) begin
            if (CNT_W'(i) == pos) begin
               cell_in[i] = req_tdata;
            end else if (CNT_W'(i) > pos) begin
               cell_in[i] = prev_w;
            end
         end else if (pop_ok) begin
            if (CNT_W'(i) >= pos) begin
               cell_in[i] = next_w;
            end
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_empty_in = is_pop && is_empty;
         rsp_full_in  = is_push && is_full;
         if (push_ok) begin
            count_in = count_ff + 1'b1;
         end else if (pop_ok) begin
            count_in    = count_ff - 1'b1;
            rsp_data_in = cell_ff[pos_idx];
         end else if (is_pop) begin
            rsp_data_in = EMPTY_VALUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      if (accept) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_full_ff, rsp_empty_ff};

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && push_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && pop_ok |=> count_ff == $past(count_ff) - 1'b1)
      else $error("accepted pop did not shrink the queue");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty_ff && rsp_full_ff))
      else $error("empty and full flags raised together");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      accept && is_pop && is_empty |=> rsp_valid_ff && rsp_empty_ff
         && rsp_data_ff == EMPTY_VALUE)
      else $error("pop on empty queue gave wrong response");
`endif

endmodule
